// File: rtl/core/link_failover_controller_macros.svh
// Assertion macros shared by the checker of the failover controller.
// Each macro samples on the rising clock edge and is quiet while reset is held.
`ifndef LINK_FAILOVER_CONTROLLER_MACROS_SVH
`define LINK_FAILOVER_CONTROLLER_MACROS_SVH

// A property that must hold at every sampled edge.
`define LFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define LFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lfc_pkg.sv
`default_nettype none

package lfc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned LimitW   = 20;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgWiredPresent     = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWiredLinkTimeout = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgWlessLinkTimeout = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgCloudTimeout     = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [LimitW-1:0] WiredLinkTimeoutRst = 20'd30000;
  localparam logic [LimitW-1:0] WlessLinkTimeoutRst = 20'd30000;
  localparam logic [LimitW-1:0] CloudTimeoutRst     = 20'd60000;

  typedef enum logic [2:0] {
    StWiredStart = 3'd0,
    StWiredWait  = 3'd1,
    StWiredCloud = 3'd2,
    StWiredUp    = 3'd3,
    StWlessStart = 3'd4,
    StWlessWait  = 3'd5,
    StWlessCloud = 3'd6,
    StWlessUp    = 3'd7
  } lfc_state_e;

  typedef struct packed {
    logic              wired_present;
    logic [LimitW-1:0] wired_link_timeout_ms;
    logic [LimitW-1:0] wireless_link_timeout_ms;
    logic [LimitW-1:0] cloud_timeout_ms;
  } lfc_cfg_t;

  // Declared from the highest bit down so that the last field lands in bit 0.
  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             wireless_credentials;
    logic             wireless_ready;
    logic             wired_ready;
    logic             cloud_up;
  } lfc_in_t;

  typedef struct packed {
    logic              first_connection;
    logic [CountW-1:0] reconnect_count;
    logic              cloud_disconnect;
    logic              cloud_connect;
    logic              wireless_disconnect;
    logic              wireless_connect;
    logic              wired_disconnect;
    logic              wired_connect;
    logic              session_up;
    logic [2:0]        link_state;
  } lfc_result_t;

endpackage

`default_nettype wire

// File: rtl/core/lfc_cfg.sv
`default_nettype none

module lfc_cfg import lfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_index_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output lfc_cfg_t                 cfg_o
);

  lfc_cfg_t cfg_q;

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wired_present            <= 1'b0;
      cfg_q.wired_link_timeout_ms    <= WiredLinkTimeoutRst;
      cfg_q.wireless_link_timeout_ms <= WlessLinkTimeoutRst;
      cfg_q.cloud_timeout_ms         <= CloudTimeoutRst;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        CfgWiredPresent:     cfg_q.wired_present            <= wr_data_i[0];
        CfgWiredLinkTimeout: cfg_q.wired_link_timeout_ms    <= wr_data_i[LimitW-1:0];
        CfgWlessLinkTimeout: cfg_q.wireless_link_timeout_ms <= wr_data_i[LimitW-1:0];
        CfgCloudTimeout:     cfg_q.cloud_timeout_ms         <= wr_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/lfc_core.sv
`default_nettype none

module lfc_core import lfc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  lfc_in_t    in_i,
  input  lfc_cfg_t   cfg_i,
  output lfc_result_t res_o
);

  lfc_state_e        state_q, state_d;
  logic [TimeW-1:0]  timer_start_q, timer_start_d;
  logic [LimitW-1:0] timer_limit_q, timer_limit_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  elapsed;
  logic              expired;
  logic              wc, wd, lc, ld, cc, cd;

  // The elapsed time wraps with the free-running clock.
  assign elapsed = in_i.now_ms - timer_start_q;
  assign expired = elapsed > {{(TimeW-LimitW){1'b0}}, timer_limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StWiredStart;
      timer_start_q <= '0;
      timer_limit_q <= '0;
      count_q       <= '0;
    end else if (step_i) begin
      state_q       <= state_d;
      timer_start_q <= timer_start_d;
      timer_limit_q <= timer_limit_d;
      count_q       <= count_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    timer_start_d = timer_start_q;
    timer_limit_d = timer_limit_q;
    count_d       = count_q;
    {wc, wd, lc, ld, cc, cd} = 6'b0;

    if (in_i.cloud_up) begin
      // A live cloud session pulls any pending state straight to connected.
      unique case (state_q)
        StWiredStart, StWiredWait, StWiredCloud: begin
          state_d = StWiredUp;
          if (count_q != '1) count_d = count_q + 1'b1;
        end
        StWlessStart, StWlessWait, StWlessCloud: begin
          state_d = StWlessUp;
          if (count_q != '1) count_d = count_q + 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (state_q)
        StWiredUp: begin
          cd = 1'b1; wd = 1'b1; state_d = StWiredStart;
        end
        StWiredStart: begin
          if (!cfg_i.wired_present) begin
            state_d = StWlessStart;
          end else begin
            wc = 1'b1;
            timer_start_d = in_i.now_ms;
            timer_limit_d = cfg_i.wired_link_timeout_ms;
            state_d = StWiredWait;
          end
        end
        StWiredWait: begin
          if (in_i.wired_ready) begin
            cc = 1'b1;
            timer_start_d = in_i.now_ms;
            timer_limit_d = cfg_i.cloud_timeout_ms;
            state_d = StWiredCloud;
          end else if (expired) begin
            wd = 1'b1; state_d = StWlessStart;
          end
        end
        StWiredCloud: begin
          if (!in_i.wired_ready || expired) begin
            cd = 1'b1; wd = 1'b1; state_d = StWlessStart;
          end
        end
        StWlessUp: begin
          cd = 1'b1; ld = 1'b1; state_d = StWiredStart;
        end
        StWlessStart: begin
          if (!in_i.wireless_credentials) begin
            state_d = StWiredStart;
          end else begin
            lc = 1'b1;
            timer_start_d = in_i.now_ms;
            timer_limit_d = cfg_i.wireless_link_timeout_ms;
            state_d = StWlessWait;
          end
        end
        StWlessWait: begin
          if (in_i.wireless_ready) begin
            cc = 1'b1;
            timer_start_d = in_i.now_ms;
            timer_limit_d = cfg_i.cloud_timeout_ms;
            state_d = StWlessCloud;
          end else if (expired) begin
            ld = 1'b1; state_d = StWiredStart;
          end
        end
        default: begin
          // Wireless cloud wait: a lost link and a timeout end the same way.
          if (!in_i.wireless_ready || expired) begin
            cd = 1'b1; ld = 1'b1; state_d = StWiredStart;
          end
        end
      endcase
    end

    res_o.link_state          = state_d;
    res_o.session_up          = in_i.cloud_up;
    res_o.wired_connect       = wc;
    res_o.wired_disconnect    = wd;
    res_o.wireless_connect    = lc;
    res_o.wireless_disconnect = ld;
    res_o.cloud_connect       = cc;
    res_o.cloud_disconnect    = cd;
    res_o.reconnect_count     = count_d;
    res_o.first_connection    = (count_d == {{(CountW-1){1'b0}}, 1'b1});
  end

endmodule

`default_nettype wire

// File: rtl/core/link_failover_controller.sv
`default_nettype none

// Link failover controller. Each input beat is one poll of the network status:
// the cloud, wired and wireless ready flags, whether wireless credentials are
// stored, and a free-running millisecond time. The controller first tries the
// wired link (when configured present), falls back to wireless, and then waits
// for a cloud session over the link that came up; each output beat carries the
// new state, one-poll connect and disconnect commands for both links and the
// cloud, and a saturating count of entries into a connected state. Exactly one
// output beat is produced per input beat, in order. A poll is captured in an
// input register, evaluated against the state, timer and counter registers, and
// its result lands in an output register. One poll is accepted per clock cycle
// while the output register is empty or draining; when a result waits for the
// downstream side, the input register can still take one poll and holds it
// until the output register drains. Configuration writes are taken in any cycle
// but must only be issued while no poll is in flight.
module link_failover_controller import lfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Poll beats. tdata from bit 0: cloud_up, wired_ready, wireless_ready,
  // wireless_credentials, now_ms[31:0], four zero bits.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,

  // Result beats. tdata from bit 0: link_state[2:0], session_up, wired_connect,
  // wired_disconnect, wireless_connect, wireless_disconnect, cloud_connect,
  // cloud_disconnect, reconnect_count[15:0], first_connection, five zero bits.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,

  // Register writes: 0 wired_present, 1 wired link timeout, 2 wireless link
  // timeout, 3 cloud timeout; other indexes are ignored.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned InFieldW  = $bits(lfc_in_t);
  localparam int unsigned OutFieldW = $bits(lfc_result_t);

  logic        in_valid_q;
  lfc_in_t     in_q;
  logic        out_valid_q;
  lfc_result_t out_q;
  lfc_result_t res;
  lfc_cfg_t    cfg;
  logic        in_accept;
  logic        advance;

  // The held poll moves on whenever the output register is empty or emptying.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= lfc_in_t'(s_axis_tdata[InFieldW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  lfc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-OutFieldW){1'b0}}, out_q};

endmodule

`default_nettype wire

// File: rtl/core/lfc_checker.sv
`default_nettype none

`include "link_failover_controller_macros.svh"

module lfc_props import lfc_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result beat keeps its contents.
  `LFC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result beat changed while stalled")

  // With the cloud session up the controller always sits in a connected state.
  `LFC_ASSERT(a_up_state, !m_axis_tvalid || !m_axis_tdata[3] || (m_axis_tdata[1:0] == 2'b11), "cloud up outside a connected state")

  // No command is issued in a poll that finds the cloud up.
  `LFC_ASSERT(a_up_quiet, !m_axis_tvalid || !m_axis_tdata[3] || (m_axis_tdata[9:4] == 6'b0), "command issued while cloud up")

  // Opening the cloud session always enters a cloud wait state.
  `LFC_ASSERT(a_cc_state, !m_axis_tvalid || !m_axis_tdata[8] || (m_axis_tdata[1:0] == 2'b10), "cloud connect outside a cloud wait state")

  // The first-connection flag tracks a count of exactly one.
  `LFC_ASSERT(a_first, !m_axis_tvalid || (m_axis_tdata[26] == (m_axis_tdata[25:10] == 16'd1)), "first connection flag disagrees with count")

endmodule

bind link_failover_controller lfc_props u_lfc_props (.*);

`default_nettype wire
